### rtl/core/nearest_point_on_block_walkways_defines.svh
// ----------------------------------------------------------------------------
// Nearest walkway point: assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and disabled
// while reset is held.
// ----------------------------------------------------------------------------
`ifndef NEAREST_POINT_ON_BLOCK_WALKWAYS_DEFINES_SVH
`define NEAREST_POINT_ON_BLOCK_WALKWAYS_DEFINES_SVH

// property that holds at every edge out of reset
`define NPW_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// consequence that must hold in the cycle after the antecedent
`define NPW_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/npw_pkg.sv
// ----------------------------------------------------------------------------
// Nearest walkway point: package
// Widths, register indexes, reset values, segment codes and shared types.
// ----------------------------------------------------------------------------
package npw_pkg;

  // coordinate format, signed Q12.8
  localparam int unsigned COORD_W = 21;
  localparam int unsigned FRAC_W  = 8;
  localparam int unsigned DIFF_W  = COORD_W + 1;
  localparam int unsigned SQ_W    = 2 * COORD_W;
  localparam int unsigned DIST_W  = SQ_W + 1;

  // register field widths
  localparam int unsigned CELLS_W = 7;
  localparam int unsigned BORD_W  = 4;
  localparam int unsigned PITCH_W = 6;
  localparam int unsigned ROAD_W  = 5;
  localparam int unsigned INSET_W = 8;
  localparam int unsigned PROD_W  = BORD_W + PITCH_W;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_CELLS_ACROSS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_DOWN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BORDER_ACROSS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BORDER_DOWN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_WIDTH   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_HEIGHT  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ROAD_SPAN     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_WALK_INSET    = 3'd7;

  // reset values
  localparam logic [CELLS_W-1:0] RST_CELLS  = 7'd8;
  localparam logic [BORD_W-1:0]  RST_BORDER = 4'd1;
  localparam logic [PITCH_W-1:0] RST_PITCH  = 6'd8;
  localparam logic [ROAD_W-1:0]  RST_ROAD   = 5'd2;
  localparam logic [INSET_W-1:0] RST_INSET  = 8'd51;

  localparam logic [PITCH_W-1:0] PITCH_MAX = 6'd32;
  localparam int unsigned MAX_CELLS_DEF = 64;

  // segment codes in walk order
  localparam int unsigned SEG_W = 3;
  localparam logic [SEG_W-1:0] SEG_V0_V1 = 3'd0;
  localparam logic [SEG_W-1:0] SEG_V1_V4 = 3'd1;
  localparam logic [SEG_W-1:0] SEG_V4_V2 = 3'd2;
  localparam logic [SEG_W-1:0] SEG_V2_V3 = 3'd3;
  localparam logic [SEG_W-1:0] SEG_V3_V5 = 3'd4;
  localparam logic [SEG_W-1:0] SEG_V5_V0 = 3'd5;
  localparam logic [SEG_W-1:0] SEG_V4_V5 = 3'd6;
  localparam logic [SEG_W-1:0] SEG_LAST  = SEG_V4_V5;

  typedef struct packed {
    logic [CELLS_W-1:0] cells_across;
    logic [CELLS_W-1:0] cells_down;
    logic [BORD_W-1:0]  border_across;
    logic [BORD_W-1:0]  border_down;
    logic [PITCH_W-1:0] block_width;
    logic [PITCH_W-1:0] block_height;
    logic [ROAD_W-1:0]  road_span;
    logic [INSET_W-1:0] walk_inset;
  } npw_cfg_t;

  // one segment test request from the sequencer
  typedef struct packed {
    logic               clear;
    logic               vld;
    logic [SEG_W-1:0]   seg;
    logic [COORD_W-1:0] xl;
    logic [COORD_W-1:0] xr;
    logic [COORD_W-1:0] xm;
    logic [COORD_W-1:0] yb;
    logic [COORD_W-1:0] yt;
  } npw_issue_t;

  typedef struct packed {
    logic busy;
    logic have;
  } npw_stat_t;

endpackage

### rtl/core/npw_ifs.sv
// ----------------------------------------------------------------------------
// Nearest walkway point: channel interfaces
// Query, result and configuration write channels with valid/ready.
// ----------------------------------------------------------------------------
interface npw_query_if import npw_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] query_x;
  logic signed [COORD_W-1:0] query_y;

  modport source (output valid, output query_x, output query_y, input ready);
  modport sink   (input valid, input query_x, input query_y, output ready);
endinterface

interface npw_result_if import npw_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] nearest_x;
  logic signed [COORD_W-1:0] nearest_y;
  logic                      no_walkway;

  modport source (output valid, output nearest_x, output nearest_y, output no_walkway,
                  input ready);
  modport sink   (input valid, input nearest_x, input nearest_y, input no_walkway,
                  output ready);
endinterface

interface npw_cfg_if import npw_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/core/nearest_point_on_block_walkways.sv
// ----------------------------------------------------------------------------
// Nearest walkway point: a query is taken in the idle state; with no cells it goes
// straight to the done state, else through prep, init, mid, the segment run and
// drain; the result loads from done once the result register is free, and the
// next query is taken back in idle. One item at a time; the segment pipeline
// tests one segment per cycle in the run, seven per cell over the whole grid
// Reset restores the register defaults and leaves the block idle, no clearing pass
// ----------------------------------------------------------------------------
module nearest_point_on_block_walkways import npw_pkg::*; #(
  parameter int unsigned MAX_CELLS = MAX_CELLS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  npw_query_if.sink           query_i,
  npw_result_if.source        result_o,
  npw_cfg_if.sink             cfg_i
);

  npw_cfg_t                  cfg_q;
  npw_issue_t                issue;
  npw_stat_t                 stat;
  logic                      in_ready, out_load, out_free;
  logic signed [COORD_W-1:0] qx_q, qy_q, best_x, best_y;
  logic                      out_valid_q;
  logic signed [COORD_W-1:0] out_x_q, out_y_q;
  logic                      out_none_q;

  // configuration registers, always ready
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cells_across  <= RST_CELLS;
      cfg_q.cells_down    <= RST_CELLS;
      cfg_q.border_across <= RST_BORDER;
      cfg_q.border_down   <= RST_BORDER;
      cfg_q.block_width   <= RST_PITCH;
      cfg_q.block_height  <= RST_PITCH;
      cfg_q.road_span     <= RST_ROAD;
      cfg_q.walk_inset    <= RST_INSET;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_CELLS_ACROSS:  cfg_q.cells_across  <= cfg_i.data[CELLS_W-1:0];
        REG_CELLS_DOWN:    cfg_q.cells_down    <= cfg_i.data[CELLS_W-1:0];
        REG_BORDER_ACROSS: cfg_q.border_across <= cfg_i.data[BORD_W-1:0];
        REG_BORDER_DOWN:   cfg_q.border_down   <= cfg_i.data[BORD_W-1:0];
        REG_BLOCK_WIDTH:   cfg_q.block_width   <= cfg_i.data[PITCH_W-1:0];
        REG_BLOCK_HEIGHT:  cfg_q.block_height  <= cfg_i.data[PITCH_W-1:0];
        REG_ROAD_SPAN:     cfg_q.road_span     <= cfg_i.data[ROAD_W-1:0];
        REG_WALK_INSET:    cfg_q.walk_inset    <= cfg_i.data[INSET_W-1:0];
        default: ;
      endcase
    end
  end

  // query capture
  assign query_i.ready = in_ready;

  always_ff @(posedge clk_i) begin
    if (query_i.valid && in_ready) begin
      qx_q <= query_i.query_x;
      qy_q <= query_i.query_y;
    end
  end

  npw_seq #(
    .MAX_CELLS (MAX_CELLS)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (query_i.valid),
    .in_ready_o (in_ready),
    .out_free_i (out_free),
    .out_load_o (out_load),
    .stat_i     (stat),
    .issue_o    (issue)
  );

  npw_seg u_seg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .issue_i  (issue),
    .qx_i     (qx_q),
    .qy_i     (qy_q),
    .best_x_o (best_x),
    .best_y_o (best_y),
    .stat_o   (stat)
  );

  // result register
  assign out_free = !out_valid_q || result_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_x_q    <= best_x;
      out_y_q    <= best_y;
      out_none_q <= !stat.have;
    end
  end

  assign result_o.valid      = out_valid_q;
  assign result_o.nearest_x  = out_x_q;
  assign result_o.nearest_y  = out_y_q;
  assign result_o.no_walkway = out_none_q;

endmodule

### rtl/core/npw_seq.sv
// ----------------------------------------------------------------------------
// Nearest walkway point: sequencer
// Walks cells x outer, y inner, and the seven segments of each cell, keeping
// the cell's walkway edges in registers stepped by one block pitch.
// ----------------------------------------------------------------------------
module npw_seq import npw_pkg::*; #(
  parameter int unsigned MAX_CELLS = MAX_CELLS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  npw_cfg_t   cfg_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       out_free_i,
  output logic       out_load_o,
  input  npw_stat_t  stat_i,
  output npw_issue_t issue_o
);

  localparam int unsigned CNT_W = $clog2(MAX_CELLS + 1);
  localparam int unsigned HI_W  = COORD_W - FRAC_W;
  localparam logic [CELLS_W-1:0] MAX_CNT = CELLS_W'(MAX_CELLS);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PREP  = 3'd1;
  localparam logic [2:0] ST_INIT  = 3'd2;
  localparam logic [2:0] ST_MID   = 3'd3;
  localparam logic [2:0] ST_RUN   = 3'd4;
  localparam logic [2:0] ST_DRAIN = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  function automatic logic [PITCH_W-1:0] limit_pitch(input logic [PITCH_W-1:0] p);
    logic [PITCH_W-1:0] r;
    r = p;
    if (p == '0) r = PITCH_W'(1);
    else if (p > PITCH_MAX) r = PITCH_MAX;
    return r;
  endfunction

  logic [2:0]         state_q, state_d;
  logic [CNT_W-1:0]   i_q, i_d, j_q, j_d;
  logic [SEG_W-1:0]   k_q, k_d;
  logic [PROD_W-1:0]  prod_x_q, prod_x_d, prod_y_q, prod_y_d;
  logic [COORD_W-1:0] xl_q, xl_d, xr_q, xr_d, xm_q, xm_d;
  logic [COORD_W-1:0] yb_q, yb_d, yt_q, yt_d, yb0_q, yb0_d, yt0_q, yt0_d;

  logic [CNT_W-1:0]   nx, ny;
  logic [PITCH_W-1:0] bw, bh;
  logic [COORD_W-1:0] step_x, step_y;
  logic [COORD_W:0]   mid_sum;

  // clipped counts and pitches
  assign nx = (cfg_i.cells_across > MAX_CNT) ? CNT_W'(MAX_CELLS)
                                             : cfg_i.cells_across[CNT_W-1:0];
  assign ny = (cfg_i.cells_down > MAX_CNT) ? CNT_W'(MAX_CELLS)
                                           : cfg_i.cells_down[CNT_W-1:0];
  assign bw = limit_pitch(cfg_i.block_width);
  assign bh = limit_pitch(cfg_i.block_height);
  assign step_x  = COORD_W'({bw, {FRAC_W{1'b0}}});
  assign step_y  = COORD_W'({bh, {FRAC_W{1'b0}}});
  assign mid_sum = {1'b0, xl_q} + {1'b0, xr_q};

  // next state and walk registers
  always_comb begin
    state_d  = state_q;
    i_d      = i_q;
    j_d      = j_q;
    k_d      = k_q;
    prod_x_d = prod_x_q;
    prod_y_d = prod_y_q;
    xl_d     = xl_q;
    xr_d     = xr_q;
    xm_d     = xm_q;
    yb_d     = yb_q;
    yt_d     = yt_q;
    yb0_d    = yb0_q;
    yt0_d    = yt0_q;
    in_ready_o    = 1'b0;
    out_load_o    = 1'b0;
    issue_o.clear = 1'b0;
    issue_o.vld   = 1'b0;
    issue_o.seg   = k_q;
    issue_o.xl    = xl_q;
    issue_o.xr    = xr_q;
    issue_o.xm    = xm_q;
    issue_o.yb    = yb_q;
    issue_o.yt    = yt_q;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          issue_o.clear = 1'b1;
          state_d = (nx == '0 || ny == '0) ? ST_DONE : ST_PREP;
        end
      end
      ST_PREP: begin
        prod_x_d = PROD_W'(cfg_i.border_across) * PROD_W'(bw);
        prod_y_d = PROD_W'(cfg_i.border_down) * PROD_W'(bh);
        state_d  = ST_INIT;
      end
      ST_INIT: begin
        // edges of the first cell
        xl_d  = {HI_W'(prod_x_q) + HI_W'(cfg_i.road_span), {FRAC_W{1'b0}}}
                + COORD_W'(cfg_i.walk_inset);
        xr_d  = {HI_W'(prod_x_q) + HI_W'(bw), {FRAC_W{1'b0}}}
                - COORD_W'(cfg_i.walk_inset);
        yb_d  = {HI_W'(prod_y_q) + HI_W'(cfg_i.road_span), {FRAC_W{1'b0}}}
                + COORD_W'(cfg_i.walk_inset);
        yt_d  = {HI_W'(prod_y_q) + HI_W'(bh), {FRAC_W{1'b0}}}
                - COORD_W'(cfg_i.walk_inset);
        yb0_d = yb_d;
        yt0_d = yt_d;
        state_d = ST_MID;
      end
      ST_MID: begin
        xm_d = mid_sum[COORD_W:1];
        i_d  = '0;
        j_d  = '0;
        k_d  = '0;
        state_d = ST_RUN;
      end
      ST_RUN: begin
        issue_o.vld = 1'b1;
        if (k_q == SEG_LAST) begin
          k_d = '0;
          if (j_q == ny - CNT_W'(1)) begin
            j_d  = '0;
            yb_d = yb0_q;
            yt_d = yt0_q;
            if (i_q == nx - CNT_W'(1)) begin
              state_d = ST_DRAIN;
            end else begin
              i_d  = i_q + CNT_W'(1);
              xl_d = xl_q + step_x;
              xr_d = xr_q + step_x;
              xm_d = xm_q + step_x;
            end
          end else begin
            j_d  = j_q + CNT_W'(1);
            yb_d = yb_q + step_y;
            yt_d = yt_q + step_y;
          end
        end else begin
          k_d = k_q + SEG_W'(1);
        end
      end
      ST_DRAIN: begin
        if (!stat_i.busy) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free_i) begin
          out_load_o = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
    end
  end

  // cell edge registers
  always_ff @(posedge clk_i) begin
    prod_x_q <= prod_x_d;
    prod_y_q <= prod_y_d;
    xl_q     <= xl_d;
    xr_q     <= xr_d;
    xm_q     <= xm_d;
    yb_q     <= yb_d;
    yt_q     <= yt_d;
    yb0_q    <= yb0_d;
    yt0_q    <= yt0_d;
  end

endmodule

### rtl/core/npw_seg.sv
// ----------------------------------------------------------------------------
// Nearest walkway point: segment test unit
// Three-stage pipeline shared by every segment: clamp and difference, two
// squares, then distance sum and keep-the-best compare.
// ----------------------------------------------------------------------------
module npw_seg import npw_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  npw_issue_t                issue_i,
  input  logic signed [COORD_W-1:0] qx_i,
  input  logic signed [COORD_W-1:0] qy_i,
  output logic signed [COORD_W-1:0] best_x_o,
  output logic signed [COORD_W-1:0] best_y_o,
  output npw_stat_t                 stat_o
);

  function automatic logic signed [COORD_W-1:0] clamp_to(
    input logic signed [COORD_W-1:0] q,
    input logic signed [COORD_W-1:0] a,
    input logic signed [COORD_W-1:0] b
  );
    logic signed [COORD_W-1:0] lo;
    logic signed [COORD_W-1:0] hi;
    logic signed [COORD_W-1:0] r;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    r  = q;
    if (q < lo) r = lo;
    else if (q > hi) r = hi;
    return r;
  endfunction

  logic signed [COORD_W-1:0] xl, xr, xm, yb, yt;
  logic signed [COORD_W-1:0] ax, bx, ay, by, px, py;

  logic                      p1_vld_q;
  logic signed [COORD_W-1:0] p1_px_q, p1_py_q;
  logic signed [DIFF_W-1:0]  p1_dx_q, p1_dy_q;
  logic                      p2_vld_q;
  logic signed [COORD_W-1:0] p2_px_q, p2_py_q;
  logic [SQ_W-1:0]           p2_dx2_q, p2_dy2_q;
  logic signed [2*DIFF_W-1:0] sq_x, sq_y;
  logic [DIST_W-1:0]         dist_sum, best_d_q;
  logic                      have_q, take;
  logic signed [COORD_W-1:0] best_x_q, best_y_q;

  assign xl = $signed(issue_i.xl);
  assign xr = $signed(issue_i.xr);
  assign xm = $signed(issue_i.xm);
  assign yb = $signed(issue_i.yb);
  assign yt = $signed(issue_i.yt);

  // segment endpoints
  always_comb begin
    unique case (issue_i.seg)
      SEG_V0_V1: begin ax = xl; bx = xl; ay = yb; by = yt; end
      SEG_V1_V4: begin ax = xl; bx = xm; ay = yt; by = yt; end
      SEG_V4_V2: begin ax = xm; bx = xr; ay = yt; by = yt; end
      SEG_V2_V3: begin ax = xr; bx = xr; ay = yt; by = yb; end
      SEG_V3_V5: begin ax = xr; bx = xm; ay = yb; by = yb; end
      SEG_V5_V0: begin ax = xm; bx = xl; ay = yb; by = yb; end
      SEG_V4_V5: begin ax = xm; bx = xm; ay = yt; by = yb; end
      default:   begin ax = xl; bx = xl; ay = yb; by = yt; end
    endcase
  end

  assign px = clamp_to(qx_i, ax, bx);
  assign py = clamp_to(qy_i, ay, by);

  // squares of the offsets
  assign sq_x = p1_dx_q * p1_dx_q;
  assign sq_y = p1_dy_q * p1_dy_q;

  // distance and strict compare, earliest segment keeps a tie
  assign dist_sum = DIST_W'(p2_dx2_q) + DIST_W'(p2_dy2_q);
  assign take     = p2_vld_q && (!have_q || dist_sum < best_d_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q <= 1'b0;
      p2_vld_q <= 1'b0;
      have_q   <= 1'b0;
    end else begin
      p1_vld_q <= issue_i.vld;
      p2_vld_q <= p1_vld_q;
      if (issue_i.clear) have_q <= 1'b0;
      else if (take) have_q <= 1'b1;
    end
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    p1_px_q  <= px;
    p1_py_q  <= py;
    p1_dx_q  <= DIFF_W'(qx_i) - DIFF_W'(px);
    p1_dy_q  <= DIFF_W'(qy_i) - DIFF_W'(py);
    p2_px_q  <= p1_px_q;
    p2_py_q  <= p1_py_q;
    p2_dx2_q <= sq_x[SQ_W-1:0];
    p2_dy2_q <= sq_y[SQ_W-1:0];
    if (issue_i.clear) begin
      best_x_q <= '0;
      best_y_q <= '0;
      best_d_q <= '0;
    end else if (take) begin
      best_x_q <= p2_px_q;
      best_y_q <= p2_py_q;
      best_d_q <= dist_sum;
    end
  end

  assign best_x_o    = best_x_q;
  assign best_y_o    = best_y_q;
  assign stat_o.busy = p1_vld_q | p2_vld_q;
  assign stat_o.have = have_q;

endmodule

### rtl/core/npw_checker.sv
// ----------------------------------------------------------------------------
// Nearest walkway point: port checker
// Watches the query and result channels of the top level over time.
// ----------------------------------------------------------------------------
`include "nearest_point_on_block_walkways_defines.svh"

module npw_checker import npw_pkg::*; (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic signed [COORD_W-1:0] out_x_i,
  input logic signed [COORD_W-1:0] out_y_i,
  input logic                      out_none_i
);

  // a stalled result beat holds
  `NPW_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_x_i) && $stable(out_y_i) && $stable(out_none_i), "result beat changed while stalled")

  // one query in flight at a time
  `NPW_ASSERT_NEXT(a_single_item, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i, "query accepted while busy")

  // an empty grid answers with the origin
  `NPW_ASSERT(a_empty_origin, clk_i, rst_ni, (out_valid_i && out_none_i) |-> (out_x_i == 0 && out_y_i == 0), "empty result not at origin")

  // no result appears in the cycle right after a query is taken
  `NPW_ASSERT_NEXT(a_no_instant, clk_i, rst_ni, in_valid_i && in_ready_i, !$rose(out_valid_i), "result too early")

endmodule

bind nearest_point_on_block_walkways npw_checker u_npw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (query_i.valid),
  .in_ready_i  (query_i.ready),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .out_x_i     (result_o.nearest_x),
  .out_y_i     (result_o.nearest_y),
  .out_none_i  (result_o.no_walkway)
);
